FILE: design/sva_pkg.sv
// shared types and fixed widths of the supply voltage moving average
package sva_pkg;

  // width of the calibration divisor register
  localparam int unsigned DivBits = 10;

  // width of the voltage result field
  localparam int unsigned ResultBits = 17;

  // reset value of the calibration divisor
  localparam logic [DivBits-1:0] DivisorReset = 10'd467;

  // scale applied to the averaged reading before the divide
  localparam int unsigned ScaleShift = 2;

  // control handed from the window control logic to every window cell
  typedef struct packed {
    logic load;   // prefill: every cell takes the new reading
    logic shift;  // store: every cell takes its neighbor's value
  } sva_cell_ctrl_t;

endpackage

FILE: design/sva_cell.sv
// one window cell: holds a single reading and passes it to its neighbor
module sva_cell
  import sva_pkg::*;
#(
  parameter int unsigned Width = 15
) (
  input  logic                 clk_i,
  input  sva_cell_ctrl_t       ctrl_i,
  input  logic [Width-1:0]     fill_i,
  input  logic [Width-1:0]     prev_i,
  output logic [Width-1:0]     data_o
);

  logic [Width-1:0] data_q;
  logic [Width-1:0] data_d;

  // prefill wins over a shift
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = fill_i;
    end else if (ctrl_i.shift) begin
      data_d = prev_i;
    end
  end

  // payload only, undefined until first written
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: design/sva_divider.sv
// restoring divider, one quotient bit per cycle
module sva_divider
  import sva_pkg::*;
#(
  parameter int unsigned N = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [N-1:0]       dividend_i,
  input  logic [DivBits-1:0] divisor_i,
  output logic               done_o,
  output logic [N-1:0]       quotient_o
);

  localparam int unsigned CntBits = $clog2(N + 1);

  logic [N-1:0]         quo_q;
  logic [DivBits-1:0]   rem_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DivBits:0]     trial;
  logic [DivBits:0]     diff;
  logic                 take;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[N-1]};
    diff  = trial - {1'b0, divisor_i};
    take  = (trial >= {1'b0, divisor_i});
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntBits'(N);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[N-2:0], take};
      rem_q <= take ? diff[DivBits-1:0] : trial[DivBits-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/supply_voltage_moving_average.sv
// top level: boxcar average of supply readings scaled to tenths of a volt
//
//   channel  direction  signals                                   transaction
//   in       input      in_valid_i/in_ready_o, adc_reading_i,     in_valid_i & in_ready_o
//                       store_reading_i
//   out      output     out_valid_o/out_ready_i, voltage_tenths_o out_valid_o & out_ready_i
//   cfg      input      cfg_we_i, cfg_wdata_i                     cfg_we_i
//
// a transaction in passes through the multiply, average and divide states before its
// result is valid; the restoring divider works at one bit per cycle.
// the window is a row of cells that shift on a store; the oldest reading sits in the last cell.
// reset clears the sum, reloads the prefill count and sets the divisor to 467; cells need no clearing.
// a finished result waits in the output register while the next transaction is taken.
module supply_voltage_moving_average
  import sva_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH  = 32,
  parameter int unsigned PREFILL_COUNT = 10,
  parameter int unsigned READING_BITS  = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [DivBits-1:0]      cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [READING_BITS-1:0] adc_reading_i,
  input  logic                    store_reading_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ResultBits-1:0]   voltage_tenths_o
);

  localparam int unsigned DepthLog  = $clog2(WINDOW_DEPTH);
  localparam int unsigned SumBits   = READING_BITS + DepthLog;
  localparam int unsigned RecipBits = SumBits + 1;
  localparam int unsigned ProdBits  = SumBits + RecipBits;
  localparam int unsigned RecipSh   = SumBits + DepthLog;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecipSh) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [RecipBits-1:0] Recip = RecipFull[RecipBits-1:0];
  localparam int unsigned PfBits    = $clog2(PREFILL_COUNT + 1);
  localparam int unsigned QuoBits   = READING_BITS + ScaleShift;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_AVG  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_WAIT = 5'b10000
  } sva_state_e;

  sva_state_e                state_q, state_d;
  logic [DivBits-1:0]        divisor_q;
  logic [PfBits-1:0]         prefill_q;
  logic [SumBits-1:0]        sum_q, sum_d;
  logic [ProdBits-1:0]       prod_q;
  logic                      out_valid_q;
  logic [ResultBits-1:0]     tenths_q;
  logic                      in_fire;
  logic                      out_free;
  logic                      load_out;
  logic                      div_start;
  logic                      div_done;
  logic [READING_BITS-1:0]   avg;
  logic [QuoBits-1:0]        quotient;
  sva_cell_ctrl_t            cell_ctrl;
  logic [READING_BITS-1:0]   cell_data [WINDOW_DEPTH];

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // calibration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DivisorReset;
    end else if (cfg_we_i) begin
      divisor_q <= cfg_wdata_i;
    end
  end

  // window control and running sum
  always_comb begin
    cell_ctrl.load  = in_fire & (prefill_q != '0);
    cell_ctrl.shift = in_fire & store_reading_i;
    sum_d = sum_q;
    if (cell_ctrl.load) begin
      sum_d = SumBits'(adc_reading_i) * SumBits'(WINDOW_DEPTH);
    end else if (cell_ctrl.shift) begin
      sum_d = sum_q - SumBits'(cell_data[WINDOW_DEPTH-1]) + SumBits'(adc_reading_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      prefill_q <= PfBits'(PREFILL_COUNT);
    end else begin
      sum_q <= sum_d;
      if (cell_ctrl.load) begin
        prefill_q <= prefill_q - PfBits'(1);
      end
    end
  end

  // row of window cells, cell zero takes the new reading
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      sva_cell #(.Width(READING_BITS)) u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .fill_i (adc_reading_i),
        .prev_i (adc_reading_i),
        .data_o (cell_data[i])
      );
    end else begin : g_body
      sva_cell #(.Width(READING_BITS)) u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .fill_i (adc_reading_i),
        .prev_i (cell_data[i-1]),
        .data_o (cell_data[i])
      );
    end
  end

  // sum over depth as a multiply by the rounded-up reciprocal
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= ProdBits'(sum_q) * ProdBits'(Recip);
    end
  end

  assign avg       = prod_q[RecipSh +: READING_BITS];
  assign div_start = (state_q == ST_AVG);

  sva_divider #(.N(QuoBits)) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({avg, {ScaleShift{1'b0}}}),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_AVG;
      ST_AVG: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      tenths_q <= ResultBits'(quotient);
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign voltage_tenths_o = tenths_q;

endmodule

FILE: design/sva_checker.sv
// port checker for the supply voltage moving average, with its bind
module sva_checker
  import sva_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [ResultBits-1:0] voltage_tenths_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(voltage_tenths_o)))
    else $error("stalled result changed");

  // one transaction at a time: in_ready_o stays low after a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while a transaction is at work");

  // a new result appears only as a transaction finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind supply_voltage_moving_average sva_checker u_sva_checker (.*);

FILE: dv/sva_scoreboard.sv
// checker for the supply voltage moving average: predicts and compares each result
`timescale 1ns / 1ps

module sva_scoreboard
  import sva_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DivBits-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [14:0]           adc_reading_i,
  input  logic                  store_reading_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [ResultBits-1:0] voltage_tenths_i,
  output int unsigned           fail_count_o,
  output int unsigned           outstanding_o
);

  localparam int unsigned RingDepth    = 32;
  localparam int unsigned PrefillSteps = 10;

  // predictor state
  logic [14:0]           reading_ring [RingDepth];
  logic [4:0]            ring_slot;
  logic [3:0]            prefill_left;
  logic [19:0]           reading_sum;
  logic [DivBits-1:0]    divisor;
  logic [ResultBits-1:0] tenths_expected [$];

  // fold one reading into the window on prefill or store and return the scaled average
  function automatic logic [ResultBits-1:0] average_tenths(input logic [14:0] reading,
                                                           input logic store);
    logic [31:0] scaled;
    if (prefill_left != 0) begin
      for (int i = 0; i < RingDepth; i++) reading_ring[i] = reading;
      reading_sum = 20'(reading) * 20'(RingDepth);
      prefill_left = prefill_left - 4'd1;
    end
    if (store) begin
      reading_sum = reading_sum - 20'(reading_ring[ring_slot]) + 20'(reading);
      reading_ring[ring_slot] = reading;
      ring_slot = ring_slot + 5'd1;
    end
    scaled = (32'(reading_sum) / RingDepth) << ScaleShift;
    if (divisor == '0) return '1;
    return ResultBits'(scaled / 32'(divisor));
  endfunction

  // watch configuration, input and output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    logic [ResultBits-1:0] want;
    if (!rst_ni) begin
      ring_slot = '0;
      prefill_left = 4'(PrefillSteps);
      reading_sum = '0;
      divisor = DivisorReset;
      tenths_expected.delete();
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) divisor = cfg_wdata_i;
      // compare the result before queueing a new expectation
      if (out_valid_i && out_ready_i) begin
        if (tenths_expected.size() == 0) begin
          $error("voltage_tenths: no expectation waiting, actual %0d", voltage_tenths_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = tenths_expected.pop_front();
          if (voltage_tenths_i !== want) begin
            $error("voltage_tenths: expected %0d, actual %0d", want, voltage_tenths_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        tenths_expected.push_back(average_tenths(adc_reading_i, store_reading_i));
      outstanding_o <= tenths_expected.size();
    end
  end

endmodule

FILE: dv/tb_supply_voltage_moving_average.sv
// testbench top: drives readings and divisor writes, hands results to the checker
`timescale 1ns / 1ps

module tb_supply_voltage_moving_average;
  import sva_pkg::*;

  localparam int unsigned ReadingMax  = 32767;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleTicks = 30;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [DivBits-1:0]    cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [14:0]           adc_reading;
  logic                  store_reading;
  logic                  out_valid;
  logic                  out_ready;
  logic [ResultBits-1:0] voltage_tenths;
  int unsigned           fail_count;
  int unsigned           outstanding;
  bit                    in_steady;
  bit                    out_steady;
  int unsigned           quiet_cycles;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  supply_voltage_moving_average dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .adc_reading_i    (adc_reading),
    .store_reading_i  (store_reading),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .voltage_tenths_o (voltage_tenths)
  );

  sva_scoreboard checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .adc_reading_i    (adc_reading),
    .store_reading_i  (store_reading),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .voltage_tenths_i (voltage_tenths),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  // one input transaction; returns at the edge that accepts it
  task automatic send_reading(input logic [14:0] reading, input logic store);
    adc_reading   <= reading;
    store_reading <= store;
    in_valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // random gap after a transaction, none while the sender runs steady
  task automatic sender_gap();
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_paced(input logic [14:0] reading, input logic store);
    send_reading(reading, store);
    sender_gap();
  endtask

  // hold the sender until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // divisor write while the block is idle
  task automatic write_divisor(input logic [DivBits-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [14:0] pick_reading();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 15'(ReadingMax);
      default: return 15'($urandom_range(0, ReadingMax));
    endcase
  endfunction

  function automatic logic [DivBits-1:0] pick_divisor();
    case ($urandom_range(0, 7))
      0:       return 10'd1;
      1:       return 10'd1023;
      2:       return 10'd0;
      default: return DivBits'($urandom_range(1, 1023));
    endcase
  endfunction

  // result side: random stall per transaction, steady stretches now and then
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ready <= 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) out_steady = ($urandom_range(0, 3) == 0);
      stall = out_steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[supply_voltage_moving_average] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    quiet_cycles  = 0;
    in_steady     = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    adc_reading   <= '0;
    store_reading <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // prefill at the reset divisor, then past the end of prefill
    send_paced('0, 1'b0);
    send_paced(15'(ReadingMax), 1'b0);
    send_paced(15'(ReadingMax), 1'b1);
    send_paced('0, 1'b1);
    send_paced(15'h5555, 1'b1);
    send_paced(15'h2AAA, 1'b0);
    send_paced(15'd1, 1'b1);
    send_paced(15'd12345, 1'b1);
    send_paced(15'(ReadingMax), 1'b0);
    send_paced(15'(ReadingMax), 1'b1);
    send_paced('0, 1'b1);
    send_paced(15'd31, 1'b0);
    send_paced(15'h4000, 1'b1);
    send_paced(15'd7, 1'b1);

    // smallest divisor with full scale readings
    write_divisor(10'd1);
    repeat (5) send_paced(15'(ReadingMax), 1'b1);

    // zero divisor
    write_divisor(10'd0);
    send_paced('0, 1'b1);
    send_paced(15'(ReadingMax), 1'b0);
    send_paced(15'd100, 1'b1);

    // largest divisor
    write_divisor(10'd1023);
    send_paced(15'(ReadingMax), 1'b1);
    send_paced('0, 1'b0);
    send_paced(15'h7FFE, 1'b1);

    // random phases, each under its own divisor
    for (int phase = 0; phase < 10; phase++) begin
      write_divisor(pick_divisor());
      in_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 60; n++)
        send_paced(pick_reading(), $urandom_range(0, 3) != 0);
    end

    drain_results();
    repeat (SettleTicks) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[supply_voltage_moving_average] OK");
    end else begin
      $display("[supply_voltage_moving_average] ERROR");
    end
    $finish;
  end

endmodule
